### rtl/svg_pkg.sv
// Shared types and constants for the sequence value generator.
package svg_pkg;

  localparam int DEFAULT_VALUE_BITS = 64;
  localparam int CACHE_BITS         = 16;
  localparam int CFG_INDEX_BITS     = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_SIZE   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_LIMIT   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_LIMIT   = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CACHE_COUNT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WRAP_ENABLE = 3'd4;

  typedef enum logic [1:0] {
    OP_NEXT  = 2'd0,
    OP_SET   = 2'd1,
    OP_RESET = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVER_MAX  = 2'd1,
    ST_OVER_MIN  = 2'd2,
    ST_SET_RANGE = 2'd3
  } status_t;

endpackage

### rtl/svg_in_if.sv
// Command channel: one operation word per handshake.
interface svg_in_if #(
  parameter int VALUE_BITS = svg_pkg::DEFAULT_VALUE_BITS
);
  logic                   valid;
  logic                   ready;
  svg_pkg::opcode_t       opcode;
  logic [VALUE_BITS-1:0]  new_value;
  logic                   set_called;

  modport source (output valid, input ready, output opcode, output new_value,
                  output set_called);
  modport sink (input valid, output ready, input opcode, input new_value,
                input set_called);
endinterface

### rtl/svg_out_if.sv
// Response channel: one result word per handshake.
interface svg_out_if #(
  parameter int VALUE_BITS = svg_pkg::DEFAULT_VALUE_BITS
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_BITS-1:0]  result_value;
  logic [VALUE_BITS-1:0]  stored_after;
  logic                   called_after;
  svg_pkg::status_t       status;

  modport source (output valid, input ready, output result_value, output stored_after,
                  output called_after, output status);
  modport sink (input valid, output ready, input result_value, input stored_after,
                input called_after, input status);
endinterface

### rtl/sequence_value_generator.sv
// Top level of the bounded sequence value generator.
//
// This block keeps a stored sequence value and a called flag and serves three
// operations on the cmd channel: next value, set value and reset to minimum.
// Every accepted command word produces exactly one response word on rsp.
// All limit arithmetic runs through a single shared adder/comparator that is
// VALUE_BITS+18 bits wide, so differences of limits and the reserved jump
// (step times cache count) are compared exactly; a small state machine feeds
// that adder one operation per cycle. A reset or an unused opcode goes straight
// to the finish state, and a set checks the new value against the maximum and
// then the minimum. A next first takes the distance from the stored value to
// the limit. A first call that reserves no further values then finishes; a
// later call checks whether one step still fits and either takes it, wraps or,
// with wrap off, reports overflow. The reserved block is then checked against
// the limit and taken in one jump when it fits. The product of the step and the
// cache count is registered before it is used. When the block would cross a
// limit, the generator walks single steps instead, adding the step and then
// checking it against the limit for each reserved value. cmd.ready is high
// only while the sequencer is idle; the response sits in an output register,
// so a new command can be taken while the previous response is still waiting.
// A response that is still waiting when the next one is done holds the
// sequencer in its finish state until it is taken. Configuration writes on
// cfg_we/cfg_index/cfg_data must only be issued while no command is in flight.
// A cache count of zero behaves as one.
module sequence_value_generator #(
  parameter int VALUE_BITS = svg_pkg::DEFAULT_VALUE_BITS,
  localparam int CFG_BITS  = (VALUE_BITS > svg_pkg::CACHE_BITS) ?
                             VALUE_BITS : svg_pkg::CACHE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [svg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]                cfg_data,
  svg_in_if.sink                             cmd,
  svg_out_if.source                          rsp
);
  import svg_pkg::*;

  // Headroom: a limit difference needs one extra bit, the reserved jump
  // needs sixteen more for the cache count and one for its sign.
  localparam int D_BITS = VALUE_BITS + 1;
  localparam int P_BITS = VALUE_BITS + CACHE_BITS + 1;
  localparam int E_BITS = VALUE_BITS + CACHE_BITS + 2;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_DIFF    = 11'b00000000010,
    S_STEP    = 11'b00000000100,
    S_STEPADD = 11'b00000001000,
    S_DIST    = 11'b00000010000,
    S_JUMP    = 11'b00000100000,
    S_WADD    = 11'b00001000000,
    S_WCMP    = 11'b00010000000,
    S_SETHI   = 11'b00100000000,
    S_SETLO   = 11'b01000000000,
    S_FINISH  = 11'b10000000000
  } state_t;

  // Configuration registers.
  logic [VALUE_BITS-1:0] step_size;
  logic [VALUE_BITS-1:0] min_limit;
  logic [VALUE_BITS-1:0] max_limit;
  logic [CACHE_BITS-1:0] cache_count;
  logic                  wrap_enable;

  // Architectural state.
  logic [VALUE_BITS-1:0] stored_value;
  logic                  called_flag;

  // Per-operation working registers.
  state_t                state;
  opcode_t               op;
  logic [VALUE_BITS-1:0] nv;
  logic                  nc;
  logic                  asc;
  logic [CACHE_BITS-1:0] cnt;
  logic [D_BITS-1:0]     d;
  logic [P_BITS-1:0]     prod;
  logic [VALUE_BITS-1:0] res;
  logic [VALUE_BITS-1:0] c;
  logic                  cflag;
  logic [D_BITS-1:0]     nx;
  status_t               sts;
  logic                  upd;

  logic [CACHE_BITS-1:0] cc_eff;
  logic                  inc_pos;
  logic signed [P_BITS-1:0] prod_c;

  logic [E_BITS-1:0] inc_e, mn_e, mx_e, last_e, c_e, nv_e, d_e, prod_e, nx_e;
  logic [E_BITS-1:0] alu_a, alu_b, alu_sum;
  logic              alu_sub, alu_neg;

  logic [VALUE_BITS-1:0] stored_next;
  logic                  called_next;

  assign cc_eff  = (cache_count == '0) ? CACHE_BITS'(1) : cache_count;
  assign inc_pos = !step_size[VALUE_BITS-1] && (step_size != '0);

  // Step times remaining cache count; registered in the difference cycle.
  assign prod_c = $signed(step_size) * $signed({1'b0, cnt});

  assign inc_e  = {{(E_BITS-VALUE_BITS){step_size[VALUE_BITS-1]}}, step_size};
  assign mn_e   = {{(E_BITS-VALUE_BITS){min_limit[VALUE_BITS-1]}}, min_limit};
  assign mx_e   = {{(E_BITS-VALUE_BITS){max_limit[VALUE_BITS-1]}}, max_limit};
  assign last_e = {{(E_BITS-VALUE_BITS){stored_value[VALUE_BITS-1]}}, stored_value};
  assign c_e    = {{(E_BITS-VALUE_BITS){c[VALUE_BITS-1]}}, c};
  assign nv_e   = {{(E_BITS-VALUE_BITS){nv[VALUE_BITS-1]}}, nv};
  assign d_e    = {{(E_BITS-D_BITS){d[D_BITS-1]}}, d};
  assign prod_e = {{(E_BITS-P_BITS){prod[P_BITS-1]}}, prod};
  assign nx_e   = {{(E_BITS-D_BITS){nx[D_BITS-1]}}, nx};

  assign cmd.ready = (state == S_IDLE);

  // Operand selection for the shared adder. Compares are a minus b with
  // the answer "a < b" on the sign bit.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (state)
      S_DIFF: begin
        alu_a = asc ? mx_e : mn_e;
        alu_b = last_e;
      end
      S_STEP: begin
        alu_a = asc ? d_e : inc_e;
        alu_b = asc ? inc_e : d_e;
      end
      S_STEPADD: begin
        alu_a   = last_e;
        alu_b   = inc_e;
        alu_sub = 1'b0;
      end
      S_DIST: begin
        alu_a = asc ? d_e : prod_e;
        alu_b = asc ? prod_e : d_e;
      end
      S_JUMP: begin
        alu_a   = last_e;
        alu_b   = prod_e;
        alu_sub = 1'b0;
      end
      S_WADD: begin
        alu_a   = c_e;
        alu_b   = inc_e;
        alu_sub = 1'b0;
      end
      S_WCMP: begin
        alu_a = asc ? mx_e : nx_e;
        alu_b = asc ? nx_e : mn_e;
      end
      S_SETHI: begin
        alu_a = mx_e;
        alu_b = nv_e;
      end
      S_SETLO: begin
        alu_a = nv_e;
        alu_b = mn_e;
      end
      default: begin
      end
    endcase
  end

  svg_alu #(
    .WIDTH (E_BITS)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum),
    .neg (alu_neg)
  );

  // State after the operation, as it will be committed in the finish cycle.
  assign stored_next = upd ? c : stored_value;
  assign called_next = upd ? cflag : called_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step_size    <= VALUE_BITS'(1);
      min_limit    <= VALUE_BITS'(1);
      max_limit    <= {1'b0, {(VALUE_BITS-1){1'b1}}};
      cache_count  <= CACHE_BITS'(1);
      wrap_enable  <= 1'b0;
      stored_value <= VALUE_BITS'(1);
      called_flag  <= 1'b0;
      rsp.valid    <= 1'b0;
    end else begin
      // The finish state drives the response valid itself.
      if (rsp.valid && rsp.ready && state != S_FINISH) begin
        rsp.valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STEP_SIZE:   step_size   <= cfg_data[VALUE_BITS-1:0];
          CFG_MIN_LIMIT:   min_limit   <= cfg_data[VALUE_BITS-1:0];
          CFG_MAX_LIMIT:   max_limit   <= cfg_data[VALUE_BITS-1:0];
          CFG_CACHE_COUNT: cache_count <= cfg_data[CACHE_BITS-1:0];
          CFG_WRAP_ENABLE: wrap_enable <= cfg_data[0];
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op    <= cmd.opcode;
            nv    <= cmd.new_value;
            nc    <= cmd.set_called;
            asc   <= inc_pos;
            // A first call hands out the stored value itself, so one fewer
            // value remains to be reserved.
            cnt   <= called_flag ? cc_eff : cc_eff - CACHE_BITS'(1);
            res   <= stored_value;
            sts   <= ST_OK;
            upd   <= 1'b0;
            cflag <= 1'b1;
            unique case (cmd.opcode)
              OP_NEXT:  state <= S_DIFF;
              OP_SET:   state <= S_SETHI;
              OP_RESET: begin
                c     <= min_limit;
                cflag <= 1'b0;
                upd   <= 1'b1;
                state <= S_FINISH;
              end
              default:  state <= S_FINISH;
            endcase
          end
        end

        // Distance from the stored value to the limit in the step direction.
        S_DIFF: begin
          d    <= alu_sum[D_BITS-1:0];
          prod <= prod_c;
          if (called_flag) begin
            state <= S_STEP;
          end else if (cnt == '0) begin
            c     <= stored_value;
            upd   <= 1'b1;
            state <= S_FINISH;
          end else begin
            state <= S_DIST;
          end
        end

        // Does one step still fit? If not, wrap or report overflow.
        S_STEP: begin
          if (alu_neg) begin
            if (!wrap_enable) begin
              sts   <= asc ? ST_OVER_MAX : ST_OVER_MIN;
              state <= S_FINISH;
            end else begin
              res   <= asc ? min_limit : max_limit;
              state <= S_DIST;
            end
          end else begin
            state <= S_STEPADD;
          end
        end

        S_STEPADD: begin
          res   <= alu_sum[VALUE_BITS-1:0];
          state <= S_DIST;
        end

        // Does the whole reserved block fit inside the limit?
        S_DIST: begin
          if (!alu_neg) begin
            state <= S_JUMP;
          end else begin
            c     <= stored_value;
            state <= S_WADD;
          end
        end

        S_JUMP: begin
          c     <= alu_sum[VALUE_BITS-1:0];
          upd   <= 1'b1;
          state <= S_FINISH;
        end

        // Single-step walk: add the step, then check it against the limit.
        S_WADD: begin
          nx    <= alu_sum[D_BITS-1:0];
          state <= S_WCMP;
        end

        S_WCMP: begin
          if (alu_neg && !wrap_enable) begin
            upd   <= 1'b1;
            state <= S_FINISH;
          end else begin
            c   <= alu_neg ? (asc ? min_limit : max_limit) : nx[VALUE_BITS-1:0];
            cnt <= cnt - CACHE_BITS'(1);
            if (cnt == CACHE_BITS'(1)) begin
              upd   <= 1'b1;
              state <= S_FINISH;
            end else begin
              state <= S_WADD;
            end
          end
        end

        S_SETHI: begin
          if (alu_neg) begin
            sts   <= ST_SET_RANGE;
            state <= S_FINISH;
          end else begin
            state <= S_SETLO;
          end
        end

        S_SETLO: begin
          if (alu_neg) begin
            sts <= ST_SET_RANGE;
          end else begin
            c     <= nv;
            cflag <= nc;
            upd   <= 1'b1;
          end
          state <= S_FINISH;
        end

        // Commit the state and load the response register once it is free.
        S_FINISH: begin
          if (!rsp.valid || rsp.ready) begin
            stored_value     <= stored_next;
            called_flag      <= called_next;
            rsp.valid        <= 1'b1;
            rsp.result_value <= (op == OP_NEXT && upd) ? res : stored_next;
            rsp.stored_after <= stored_next;
            rsp.called_after <= called_next;
            rsp.status       <= sts;
            state            <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/svg_alu.sv
// Shared add/subtract unit with a sign flag used for all limit compares.
module svg_alu #(
  parameter int WIDTH = svg_pkg::DEFAULT_VALUE_BITS + 18
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic             sub,
  output logic [WIDTH-1:0] sum,
  output logic             neg
);
  logic [WIDTH-1:0] b_in;

  // The operands are sign extended with enough headroom that the
  // difference never overflows, so the sign bit alone orders a and b.
  assign b_in = sub ? ~b : b;
  assign sum  = a + b_in + {{(WIDTH-1){1'b0}}, sub};
  assign neg  = sum[WIDTH-1];
endmodule

### test/sequence_value_generator_test.sv
// Self-checking testbench for the sequence value generator with a built-in predictor.
`timescale 1ns / 100ps

module sequence_value_generator_test;
  import svg_pkg::*;

  // The block runs at its default width of 64 bits. The predictor works on
  // 82-bit signed values. That is enough for limit differences (65 bits) and
  // for the reserved jump of step times cache count (80 bits), both exact.
  typedef logic signed [81:0] wide_t;

  typedef struct packed {
    opcode_t     op;
    logic [63:0] value;
    logic        flag;
  } seq_cmd_t;

  typedef struct packed {
    logic [63:0] result;
    logic [63:0] stored;
    logic        called;
    status_t     status;
  } seq_rsp_t;

  localparam logic [63:0] VAL_TOP    = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] VAL_BOTTOM = 64'h8000_0000_0000_0000;
  localparam logic [63:0] VAL_MINUS1 = 64'hffff_ffff_ffff_ffff;
  localparam logic [15:0] CACHE_TOP  = 16'hffff;
  // The opcode encoding that the block must treat as a no-op.
  localparam opcode_t     OP_UNUSED  = opcode_t'(2'd3);

  // The slowest correct run is bounded as follows. About 500 words walk at most
  // 100 single steps each on the walking path. Each response can be held off
  // for a long time by a 75 percent receiver stall. One directed word walks
  // 65535 single steps. The cycle limit covers all of that several times over.
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int PHASE_WORDS  = 40;
  localparam int RANDOM_PHASE = 12;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  svg_in_if  cmd_ch ();
  svg_out_if rsp_ch ();

  sequence_value_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The predictor's copy of the configuration registers and of the sequence state.
  logic [63:0] step_q, min_q, max_q, value_q;
  logic [15:0] cache_q;
  logic        wrap_q, called_q;

  seq_cmd_t cmd_backlog[$];  // Command words waiting for the driver.
  seq_rsp_t due_rsp[$];      // Predicted responses, oldest first.
  int       send_idle;       // Percentage of cycles in which the driver holds back.
  int       recv_idle;       // Percentage of cycles in which rsp.ready is low.
  int       errors = 0;
  int       cycles = 0;

  function automatic wide_t widen(logic [63:0] v);
    return {{18{v[63]}}, v};
  endfunction

  // A next-value operation runs against the current state. The function returns
  // the status. When the status is OK, the value handed out and the new stored
  // value come back through the output arguments.
  function automatic status_t take_next(output logic [63:0] handed,
                                        output logic [63:0] reserved);
    wide_t inc, mn, mx, last, fetch, jump, c, nx;
    logic  asc;
    inc  = widen(step_q);
    mn   = widen(min_q);
    mx   = widen(max_q);
    last = widen(value_q);
    asc  = inc > 0;
    fetch = cache_q;
    if (fetch == 0) fetch = 1;  // A cache count of zero behaves as one.
    handed   = value_q;
    reserved = value_q;
    if (!called_q) begin
      // The first call hands out the stored value itself. It uses up one of the
      // reserved values.
      fetch = fetch - 1;
      if (fetch == 0) return ST_OK;
    end else if (asc) begin
      if (mx - last < inc) begin
        if (!wrap_q) return ST_OVER_MAX;
        handed = min_q;
      end else begin
        nx = last + inc;
        handed = nx[63:0];
      end
    end else begin
      if (inc < mn - last) begin
        if (!wrap_q) return ST_OVER_MIN;
        handed = max_q;
      end else begin
        nx = last + inc;
        handed = nx[63:0];
      end
    end
    // When the whole reserved block stays inside the limits, it is taken in one jump.
    jump = inc * fetch;
    if (asc ? !(mx - last < jump) : !(jump < mn - last)) begin
      nx = jump + last;
      reserved = nx[63:0];
      return ST_OK;
    end
    // Otherwise the block walks one step at a time. At each limit it either
    // wraps or stops.
    c = last;
    while (fetch > 0) begin
      nx = c + inc;
      if (asc ? (mx < nx) : (nx < mn)) begin
        if (!wrap_q) break;
        c = asc ? mn : mx;
      end else begin
        c = nx;
      end
      fetch = fetch - 1;
    end
    reserved = c[63:0];
    return ST_OK;
  endfunction

  // The predictor applies one accepted command word to the state and returns
  // the response word that the block must produce for it.
  function automatic seq_rsp_t apply_op(seq_cmd_t w);
    seq_rsp_t    r;
    logic [63:0] handed, reserved;
    wide_t       nv;
    r.status = ST_OK;
    handed   = value_q;
    case (w.op)
      OP_NEXT: begin
        r.status = take_next(handed, reserved);
        if (r.status == ST_OK) begin
          value_q  = reserved;
          called_q = 1'b1;
        end else begin
          handed = value_q;
        end
      end
      OP_SET: begin
        nv = widen(w.value);
        if (nv > widen(max_q) || nv < widen(min_q)) begin
          r.status = ST_SET_RANGE;
        end else begin
          value_q  = w.value;
          called_q = w.flag;
        end
        handed = value_q;
      end
      OP_RESET: begin
        value_q  = min_q;
        called_q = 1'b0;
        handed   = value_q;
      end
      default: ;  // The unused opcode only reports the state.
    endcase
    r.result = handed;
    r.stored = value_q;
    r.called = called_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < 100) $display("mismatch in %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  // The driver offers the next command word unless it chooses to idle. It holds
  // the word until the block takes it.
  always @(posedge clk) begin
    seq_cmd_t word;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_ch.ready) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
        word = cmd_backlog.pop_front();
        cmd_ch.valid      <= 1'b1;
        cmd_ch.opcode     <= word.op;
        cmd_ch.new_value  <= word.value;
        cmd_ch.set_called <= word.flag;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    rsp_ch.ready <= $urandom_range(99) >= recv_idle;
  end

  // The monitor checks each response word against the oldest prediction. Each
  // accepted command word is run through the predictor. A response can never
  // belong to a command taken at the same edge, so the check goes first.
  always @(posedge clk) begin
    seq_rsp_t want;
    seq_cmd_t seen;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_rsp.size() == 0) begin
          report_mismatch("response with none expected", rsp_ch.result_value, '0);
        end else begin
          want = due_rsp.pop_front();
          if (rsp_ch.result_value !== want.result)
            report_mismatch("result_value", rsp_ch.result_value, want.result);
          if (rsp_ch.stored_after !== want.stored)
            report_mismatch("stored_after", rsp_ch.stored_after, want.stored);
          if (rsp_ch.called_after !== want.called)
            report_mismatch("called_after", 64'(rsp_ch.called_after), 64'(want.called));
          if (rsp_ch.status !== want.status)
            report_mismatch("status", 64'(rsp_ch.status), 64'(want.status));
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        seen.op    = cmd_ch.opcode;
        seen.value = cmd_ch.new_value;
        seen.flag  = cmd_ch.set_called;
        due_rsp.push_back(apply_op(seen));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // This function returns a random signed value of about 64 - sh bits.
  function automatic logic [63:0] spread(int sh);
    return $signed(rand64()) >>> sh;
  endfunction

  // The block is idle when nothing waits to be sent and nothing is in flight.
  // The check runs on the falling edge, after all updates of the rising edge.
  task automatic wait_idle();
    @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_ch.valid || due_rsp.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_STEP_SIZE:   step_q  = data;
      CFG_MIN_LIMIT:   min_q   = data;
      CFG_MAX_LIMIT:   max_q   = data;
      CFG_CACHE_COUNT: cache_q = data[15:0];
      CFG_WRAP_ENABLE: wrap_q  = data[0];
      default: ;
    endcase
  endtask

  // This task writes all five registers back to back once the block has gone
  // idle. The sequence state is kept, so a stored value can end up outside the
  // new limits.
  task automatic set_config(input logic [63:0] step, input logic [63:0] lo,
                            input logic [63:0] hi, input logic [15:0] cache,
                            input logic wrap);
    wait_idle();
    write_reg(CFG_STEP_SIZE, step);
    write_reg(CFG_MIN_LIMIT, lo);
    write_reg(CFG_MAX_LIMIT, hi);
    write_reg(CFG_CACHE_COUNT, {48'd0, cache});
    write_reg(CFG_WRAP_ENABLE, {63'd0, wrap});
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic add_word(input opcode_t op, input logic [63:0] value, input logic flag);
    seq_cmd_t w;
    w.op    = op;
    w.value = value;
    w.flag  = flag;
    cmd_backlog.push_back(w);
  endtask

  initial begin
    logic [63:0] step, lo, hi, val;
    logic [15:0] cache;
    int unsigned r, k;

    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = CFG_STEP_SIZE;
    cfg_data          = '0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.opcode     = OP_NEXT;
    cmd_ch.new_value  = '0;
    cmd_ch.set_called = 1'b0;
    rsp_ch.ready      = 1'b0;
    send_idle         = 9;
    recv_idle         = 75;

    // These are the register and state values that reset leaves behind.
    step_q   = 64'd1;
    min_q    = 64'd1;
    max_q    = VAL_TOP;
    cache_q  = 16'd1;
    wrap_q   = 1'b0;
    value_q  = 64'd1;
    called_q = 1'b0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // These words run on the reset configuration. The first call hands out the
    // minimum. A set to the maximum then makes the next call overflow, since
    // wrapping is off. Two sets below the minimum are refused. The unused
    // opcode only reports the state.
    add_word(OP_NEXT, 64'd0, 1'b0);
    add_word(OP_NEXT, VAL_MINUS1, 1'b1);
    add_word(OP_SET, VAL_TOP, 1'b1);
    add_word(OP_NEXT, 64'd0, 1'b0);
    add_word(OP_SET, 64'd0, 1'b0);
    add_word(OP_SET, VAL_BOTTOM, 1'b1);
    add_word(OP_RESET, VAL_MINUS1, 1'b1);
    add_word(OP_UNUSED, VAL_TOP, 1'b1);
    add_word(OP_NEXT, 64'd0, 1'b0);

    // The sequence descends and wraps. A call near the bottom hands out the
    // maximum, and the reserved block walks across the limit.
    set_config(-64'sd3, -64'sd10, 64'sd10, 16'd4, 1'b1);
    add_word(OP_SET, 64'sd10, 1'b1);
    add_word(OP_NEXT, 64'd0, 1'b0);
    add_word(OP_NEXT, 64'd0, 1'b0);
    add_word(OP_SET, -64'sd9, 1'b1);
    add_word(OP_NEXT, 64'd0, 1'b0);

    // The most negative step is used with a zero cache count. The second call
    // runs past the minimum without wrap.
    set_config(VAL_BOTTOM, VAL_BOTTOM, VAL_TOP, 16'd0, 1'b0);
    add_word(OP_SET, 64'd0, 1'b1);
    add_word(OP_NEXT, 64'd0, 1'b0);
    add_word(OP_NEXT, 64'd0, 1'b0);

    // The largest positive step climbs from the bottom and wraps at the top.
    set_config(VAL_TOP, VAL_BOTTOM, VAL_TOP, 16'd2, 1'b1);
    add_word(OP_SET, VAL_BOTTOM, 1'b1);
    add_word(OP_NEXT, 64'd0, 1'b0);
    add_word(OP_NEXT, 64'd0, 1'b0);
    add_word(OP_NEXT, 64'd0, 1'b0);

    // The narrowed limits leave the stored value far outside them.
    set_config(64'sd7, 64'sd0, 64'sd50, 16'd3, 1'b1);
    add_word(OP_NEXT, 64'd0, 1'b0);

    // With the largest cache count in a tiny window, the block walks every
    // reserved value around the ring.
    set_config(64'sd1, 64'sd0, 64'sd9, CACHE_TOP, 1'b1);
    add_word(OP_SET, 64'sd5, 1'b1);
    add_word(OP_NEXT, 64'd0, 1'b0);

    // A zero step with the largest cache count always fits in one jump.
    set_config(64'd0, VAL_BOTTOM, VAL_TOP, CACHE_TOP, 1'b0);
    add_word(OP_NEXT, 64'd0, 1'b0);
    add_word(OP_NEXT, 64'd0, 1'b0);

    // The random phases draw a fresh configuration each time. Windows are
    // mostly narrow, so that limits are crossed often. Most words are next
    // calls, and sets keep moving the stored value back near the limits.
    for (int p = 0; p < RANDOM_PHASE; p++) begin
      case ($urandom_range(7))
        0: step = 64'd1;
        1: step = VAL_MINUS1;
        2: step = 64'd0;
        3: step = VAL_TOP;
        4: step = VAL_BOTTOM;
        5: step = rand64();
        default: step = spread(59);
      endcase
      r = $urandom_range(0, 80);
      case ($urandom_range(5))
        0: begin
          lo = VAL_BOTTOM;
          hi = VAL_TOP;
        end
        1, 2: begin
          lo = spread(24);
          hi = lo + r;
        end
        3: begin
          hi = VAL_TOP;
          lo = VAL_TOP - r;
        end
        4: begin
          lo = VAL_BOTTOM;
          hi = VAL_BOTTOM + r;
        end
        default: begin
          lo = rand64();
          hi = rand64();
        end
      endcase
      case ($urandom_range(9))
        0: cache = 16'd0;
        1: cache = 16'd1;
        2: cache = 16'($urandom_range(9, 100));
        default: cache = 16'($urandom_range(1, 8));
      endcase
      set_config(step, lo, hi, cache, 1'($urandom_range(1)));

      // The first stage already runs at the start of the run. After it, the
      // sender and the receiver swap roles, and at the end neither one idles.
      if (p == RANDOM_PHASE / 3) begin
        send_idle = 75;
        recv_idle = 9;
      end else if (p == 2 * RANDOM_PHASE / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end

      for (int i = 0; i < PHASE_WORDS; i++) begin
        k = $urandom_range(99);
        if (k < 55) begin
          add_word(OP_NEXT, rand64(), 1'($urandom_range(1)));
        end else if (k < 82) begin
          case ($urandom_range(6))
            0: val = lo;
            1: val = hi;
            2: val = lo + $urandom_range(0, 20);
            3: val = hi - $urandom_range(0, 20);
            4: val = rand64();
            5: val = lo - 64'd1;
            default: val = hi + 64'd1;
          endcase
          add_word(OP_SET, val, 1'($urandom_range(1)));
        end else if (k < 94) begin
          add_word(OP_RESET, rand64(), 1'($urandom_range(1)));
        end else begin
          add_word(OP_UNUSED, rand64(), 1'($urandom_range(1)));
        end
      end
    end

    wait_idle();
    // Any stray response that comes after the last one expected is still
    // caught by the monitor during this wait.
    repeat (40) @(posedge clk);
    if (errors == 0 && due_rsp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
